// ===== rtl/core/dfr_pkg.sv =====
package dfr_pkg;

  localparam int SIZE_BITS_DEFAULT = 31;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [31:0] DEFAULT_PACKAGE_LIMIT = 32'd67108864;
  localparam logic [7:0] DEFAULT_HEADER_LIMIT = 8'd128;

  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  // configuration register indexes
  localparam logic CFG_PACKAGE_LIMIT = 1'b0;
  localparam logic CFG_HEADER_LIMIT = 1'b1;

  // status codes
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE = 3'd2;
  localparam logic [2:0] ST_TOO_MANY = 3'd3;
  localparam logic [2:0] ST_CLOSED = 3'd4;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic        start_req;
    logic [31:0] prior_length;
    logic [7:0]  prior_headers;
  } in_beat_t;

  typedef struct packed {
    logic       body_valid;
    logic [7:0] body_byte;
    logic       chunk_last;
    logic       message_done;
    logic [2:0] status;
  } out_beat_t;

  typedef struct packed {
    logic        addr;
    logic [31:0] wdata;
  } cfg_beat_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_blank;
    logic       is_semi;
    logic       is_cr;
    logic       is_lf;
  } byte_class_t;

  typedef struct packed {
    in_beat_t    beat;
    byte_class_t cls;
  } item_t;

endpackage

// ===== rtl/core/dfr_chan_if.sv =====
interface dfr_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/dfr_front.sv =====
module dfr_front (
  dfr_chan_if.sink        din,
  input  logic            q_full,
  output logic            q_push,
  output dfr_pkg::item_t  q_item
);
  import dfr_pkg::*;

  byte_class_t cls;
  logic [7:0] c;

  assign c = din.data.data_byte;

  always_comb begin
    cls = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      cls.is_hex = 1'b1;
      cls.hex_val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      // a-f and A-F share the low three bits: 1..6 maps to 10..15
      cls.is_hex = 1'b1;
      cls.hex_val = 4'(c[2:0]) + 4'd9;
    end
    cls.is_blank = (c == CH_SPACE) || (c == CH_TAB);
    cls.is_semi = (c == CH_SEMI);
    cls.is_cr = (c == CH_CR);
    cls.is_lf = (c == CH_LF);
  end

  assign din.ready = !q_full;
  assign q_push = din.valid && !q_full;
  assign q_item = '{beat: din.data, cls: cls};

endmodule

// ===== rtl/core/dfr_fifo.sv =====
module dfr_fifo #(
  parameter int DEPTH = dfr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dfr_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output dfr_pkg::item_t rd_item,
  output logic           empty
);
  import dfr_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t           mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/dfr_back.sv =====
module dfr_back #(
  parameter int SIZE_BITS = dfr_pkg::SIZE_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [31:0]    eff_limit,
  input  logic [7:0]     header_limit,
  input  logic           q_empty,
  input  dfr_pkg::item_t q_item,
  output logic           q_pop,
  dfr_chan_if.source     dout
);
  import dfr_pkg::*;

  localparam logic [2:0] PH_SIZE = 3'd0;
  localparam logic [2:0] PH_DATA = 3'd1;
  localparam logic [2:0] PH_BREAK = 3'd2;
  localparam logic [2:0] PH_BREAK_CR = 3'd3;
  localparam logic [2:0] PH_TRAILER = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  localparam int FL_DIGIT = 0;
  localparam int FL_EXT = 1;
  localparam int FL_CR = 2;
  localparam int FL_CONTENT = 3;

  logic [2:0]           phase, phase_next;
  logic [SIZE_BITS-1:0] chunk_remaining, chunk_remaining_next;
  logic [SIZE_BITS-1:0] size_value, size_value_next;
  logic [3:0]           line_flags, line_flags_next;
  logic [31:0]          total_length, total_length_next;
  logic [7:0]           header_count, header_count_next;
  logic [2:0]           error_code, error_code_next;

  logic                 out_valid;
  out_beat_t            out_data;
  out_beat_t            res;

  // state as seen after an optional restart
  logic [2:0]           b_phase;
  logic [SIZE_BITS-1:0] b_size;
  logic [3:0]           b_flags;
  logic [31:0]          b_total;
  logic [7:0]           b_hcount;
  logic [2:0]           b_err;
  logic [SIZE_BITS-1:0] b_rem;
  logic [SIZE_BITS-1:0] rem_dec;
  logic                 size_over;
  logic                 finish;
  byte_class_t          cls;

  assign cls = q_item.cls;
  assign q_pop = !q_empty && (!out_valid || dout.ready);
  assign dout.valid = out_valid;
  assign dout.data = out_data;

  always_comb begin
    if (q_item.beat.start_req) begin
      b_phase = PH_SIZE;
      b_rem = '0;
      b_size = '0;
      b_flags = '0;
      b_total = q_item.beat.prior_length;
      b_hcount = q_item.beat.prior_headers;
      b_err = ST_OK;
    end else begin
      b_phase = phase;
      b_rem = chunk_remaining;
      b_size = size_value;
      b_flags = line_flags;
      b_total = total_length;
      b_hcount = header_count;
      b_err = error_code;
    end
  end

  // the byte that ends a size line is already counted: total + 1 + size > limit
  assign size_over = ({1'b0, b_total} + 33'(b_size)) >= {1'b0, eff_limit};
  assign rem_dec = (b_rem != '0) ? b_rem - 1'b1 : '0;

  always_comb begin
    phase_next = b_phase;
    chunk_remaining_next = b_rem;
    size_value_next = b_size;
    line_flags_next = b_flags;
    total_length_next = b_total;
    header_count_next = b_hcount;
    error_code_next = b_err;
    finish = 1'b0;
    res = '0;

    if (b_err != ST_OK) begin
      // sticky error: hold everything
    end else if (q_item.beat.kind) begin
      if (b_phase != PH_DONE) begin
        error_code_next = ST_CLOSED;
      end
    end else if (b_phase == PH_DONE) begin
      // drop bytes past the end of the message
    end else if (b_total >= eff_limit) begin
      error_code_next = ST_TOO_LARGE;
    end else begin
      total_length_next = b_total + 32'd1;
      unique case (b_phase)
        PH_SIZE: begin
          priority if (b_flags[FL_EXT]) begin
            finish = cls.is_lf;
          end else if (b_flags[FL_CR]) begin
            if (cls.is_lf) finish = 1'b1;
            else error_code_next = ST_INVALID;
          end else if (!b_flags[FL_DIGIT]) begin
            priority if (cls.is_blank) begin
            end else if (!cls.is_hex) begin
              error_code_next = ST_INVALID;
            end else begin
              size_value_next = SIZE_BITS'(cls.hex_val);
              line_flags_next[FL_DIGIT] = 1'b1;
            end
          end else if (cls.is_hex) begin
            if (b_size[SIZE_BITS-1 -: 4] != 4'd0) begin
              error_code_next = ST_INVALID;
            end else begin
              size_value_next = {b_size[SIZE_BITS-5:0], cls.hex_val};
            end
          end else if (cls.is_semi) begin
            line_flags_next[FL_EXT] = 1'b1;
          end else if (cls.is_cr) begin
            line_flags_next[FL_CR] = 1'b1;
          end else if (cls.is_lf) begin
            finish = 1'b1;
          end else begin
            error_code_next = ST_INVALID;
          end
          if (finish) begin
            line_flags_next = '0;
            priority if (b_size == '0) begin
              phase_next = PH_TRAILER;
            end else if (size_over) begin
              error_code_next = ST_TOO_LARGE;
            end else begin
              chunk_remaining_next = b_size;
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          res.body_valid = 1'b1;
          res.body_byte = q_item.beat.data_byte;
          chunk_remaining_next = rem_dec;
          if (rem_dec == '0) begin
            res.chunk_last = 1'b1;
            phase_next = PH_BREAK;
          end
        end
        PH_BREAK, PH_BREAK_CR: begin
          priority if (cls.is_lf) begin
            phase_next = PH_SIZE;
            size_value_next = '0;
            line_flags_next = '0;
          end else if (cls.is_cr && b_phase == PH_BREAK) begin
            phase_next = PH_BREAK_CR;
          end else begin
            error_code_next = ST_INVALID;
          end
        end
        PH_TRAILER: begin
          priority if (cls.is_lf) begin
            priority if (!b_flags[FL_CONTENT]) begin
              phase_next = PH_DONE;
              res.message_done = 1'b1;
            end else if (b_hcount >= header_limit) begin
              error_code_next = ST_TOO_MANY;
            end else begin
              header_count_next = b_hcount + 8'd1;
            end
            line_flags_next = '0;
          end else if (cls.is_cr && b_flags == 4'd0) begin
            line_flags_next = 4'd0;
            line_flags_next[FL_CR] = 1'b1;
          end else begin
            line_flags_next = 4'd0;
            line_flags_next[FL_CONTENT] = 1'b1;
          end
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end
    res.status = error_code_next;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SIZE;
      chunk_remaining <= '0;
      size_value <= '0;
      line_flags <= '0;
      total_length <= '0;
      header_count <= '0;
      error_code <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        phase <= phase_next;
        chunk_remaining <= chunk_remaining_next;
        size_value <= size_value_next;
        line_flags <= line_flags_next;
        total_length <= total_length_next;
        header_count <= header_count_next;
        error_code <= error_code_next;
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/http_chunked_body_deframer.sv =====
// Path: an accepted beat is written into the queue, then parsed by the back end and
// registered into the output register that drives dout.
// Throughput: one beat per cycle while dout takes results, set by the back end's parser update.
// A small queue between front and back absorbs output stalls.
// Reset: synchronous; clears parser state, queue and output register, and loads the
// default package limit and header limit. No memory clearing pass.
module http_chunked_body_deframer #(
  parameter int SIZE_BITS = dfr_pkg::SIZE_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = dfr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  dfr_chan_if.sink   din,
  dfr_chan_if.source dout,
  dfr_chan_if.sink   cfg
);
  import dfr_pkg::*;

  logic [31:0] eff_limit;
  logic [7:0]  header_limit;
  logic        q_full;
  logic        q_empty;
  logic        q_push;
  logic        q_pop;
  item_t       q_wr_item;
  item_t       q_rd_item;

  assign cfg.ready = 1'b1;

  // a zero package limit selects the default
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_limit <= DEFAULT_PACKAGE_LIMIT;
      header_limit <= DEFAULT_HEADER_LIMIT;
    end else if (cfg.valid) begin
      unique case (cfg.data.addr)
        CFG_PACKAGE_LIMIT: begin
          eff_limit <= (cfg.data.wdata == 32'd0) ? DEFAULT_PACKAGE_LIMIT : cfg.data.wdata;
        end
        CFG_HEADER_LIMIT: begin
          header_limit <= cfg.data.wdata[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  dfr_front u_front (
    .din    (din),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_wr_item)
  );

  dfr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (q_rd_item),
    .empty   (q_empty)
  );

  dfr_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .eff_limit    (eff_limit),
    .header_limit (header_limit),
    .q_empty      (q_empty),
    .q_item       (q_rd_item),
    .q_pop        (q_pop),
    .dout         (dout)
  );

  a_out_idle_after_reset: assert property (@(posedge clk) rst |=> !dout.valid)
    else $error("result valid right after reset");

  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.data.message_done |->
      dout.data.status == ST_OK && !dout.data.body_valid)
    else $error("message done with payload or error");

  a_last_has_payload: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.data.chunk_last |-> dout.data.body_valid)
    else $error("chunk last without payload byte");

  a_payload_ok: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.data.body_valid |-> dout.data.status == ST_OK)
    else $error("payload byte carries an error status");

endmodule

// ===== tb/chunk_deframe_monitor.sv =====
module chunk_deframe_monitor #(
  parameter int SIZE_BITS = dfr_pkg::SIZE_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  dfr_pkg::in_beat_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  dfr_pkg::out_beat_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  dfr_pkg::cfg_beat_t cfg_data,
  output int                 fail_count,
  output int                 outstanding,
  output int                 results_checked,
  output int                 messages_done
);
  import dfr_pkg::*;

  typedef enum logic [2:0] {
    SEEK_SIZE, IN_DATA, AT_BREAK, BREAK_CR, IN_TRAILER, MSG_DONE
  } parse_phase_e;

  localparam logic [3:0] LN_DIGIT   = 4'd1;
  localparam logic [3:0] LN_EXT     = 4'd2;
  localparam logic [3:0] LN_CR      = 4'd4;
  localparam logic [3:0] LN_CONTENT = 4'd8;

  localparam logic [31:0] SIZE_MAX = 32'((64'd1 << SIZE_BITS) - 64'd1);

  logic [31:0]  len_cap;
  logic [7:0]   hdr_limit;
  parse_phase_e ph;
  logic [31:0]  remaining;
  logic [31:0]  size_acc;
  logic [3:0]   flags;
  logic [31:0]  total;
  logic [7:0]   hdr_count;
  logic [2:0]   err;

  out_beat_t pending_results[$];

  task automatic report(string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic logic [31:0] eff_limit();
    return (len_cap == '0) ? DEFAULT_PACKAGE_LIMIT : len_cap;
  endfunction

  // {is_hex, value}
  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - 8'h30)};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - 8'h61 + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - 8'h41 + 8'd10)};
    return 5'd0;
  endfunction

  function automatic void close_size_line();
    flags = '0;
    if (size_acc == '0) begin
      ph = IN_TRAILER;
    end else if ({1'b0, total} + {1'b0, size_acc} > {1'b0, eff_limit()}) begin
      err = ST_TOO_LARGE;
    end else begin
      remaining = size_acc;
      ph = IN_DATA;
    end
  endfunction

  function automatic void take_size_char(logic [7:0] c);
    logic [4:0] h;
    h = hex_nibble(c);
    if ((flags & LN_EXT) != '0) begin
      // extension text: skip up to the LF
      if (c == CH_LF) close_size_line();
    end else if ((flags & LN_CR) != '0) begin
      if (c == CH_LF) close_size_line();
      else err = ST_INVALID;
    end else if ((flags & LN_DIGIT) == '0) begin
      if (c != CH_SPACE && c != CH_TAB) begin
        if (!h[4]) begin
          err = ST_INVALID;
        end else begin
          size_acc = {28'd0, h[3:0]};
          flags = flags | LN_DIGIT;
        end
      end
    end else if (h[4]) begin
      if (size_acc > (SIZE_MAX >> 4)) err = ST_INVALID;
      else size_acc = {size_acc[27:0], h[3:0]};
    end else if (c == CH_SEMI) begin
      flags = flags | LN_EXT;
    end else if (c == CH_CR) begin
      flags = flags | LN_CR;
    end else if (c == CH_LF) begin
      close_size_line();
    end else begin
      err = ST_INVALID;
    end
  endfunction

  function automatic out_beat_t deframe_step(in_beat_t b);
    out_beat_t r;
    r = '0;
    if (b.start_req) begin
      ph = SEEK_SIZE;
      remaining = '0;
      size_acc = '0;
      flags = '0;
      total = b.prior_length;
      hdr_count = b.prior_headers;
      err = ST_OK;
    end
    // a set error freezes everything until the next start
    if (err == ST_OK) begin
      if (b.kind) begin
        if (ph != MSG_DONE) err = ST_CLOSED;
      end else if (ph != MSG_DONE) begin
        if ({1'b0, total} + 33'd1 > {1'b0, eff_limit()}) begin
          err = ST_TOO_LARGE;
        end else begin
          total = total + 32'd1;
          case (ph)
            SEEK_SIZE: take_size_char(b.data_byte);
            IN_DATA: begin
              r.body_valid = 1'b1;
              r.body_byte = b.data_byte;
              if (remaining != '0) remaining = remaining - 32'd1;
              if (remaining == '0) begin
                r.chunk_last = 1'b1;
                ph = AT_BREAK;
              end
            end
            AT_BREAK: begin
              if (b.data_byte == CH_LF) begin
                ph = SEEK_SIZE;
                size_acc = '0;
                flags = '0;
              end else if (b.data_byte == CH_CR) begin
                ph = BREAK_CR;
              end else begin
                err = ST_INVALID;
              end
            end
            BREAK_CR: begin
              if (b.data_byte == CH_LF) begin
                ph = SEEK_SIZE;
                size_acc = '0;
                flags = '0;
              end else begin
                err = ST_INVALID;
              end
            end
            IN_TRAILER: begin
              if (b.data_byte == CH_LF) begin
                if ((flags & LN_CONTENT) == '0) begin
                  ph = MSG_DONE;
                  r.message_done = 1'b1;
                  messages_done++;
                end else if (hdr_count >= hdr_limit) begin
                  err = ST_TOO_MANY;
                end else begin
                  hdr_count = hdr_count + 8'd1;
                end
                flags = '0;
              end else if (b.data_byte == CH_CR && flags == '0) begin
                flags = LN_CR;
              end else begin
                flags = LN_CONTENT;
              end
            end
            default: ph = MSG_DONE;
          endcase
        end
      end
    end
    r.status = err;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_beat_t want;
    string     mism;
    if (rst) begin
      len_cap = DEFAULT_PACKAGE_LIMIT;
      hdr_limit = DEFAULT_HEADER_LIMIT;
      ph = SEEK_SIZE;
      remaining = '0;
      size_acc = '0;
      flags = '0;
      total = '0;
      hdr_count = '0;
      err = ST_OK;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_data.addr == CFG_PACKAGE_LIMIT) len_cap = cfg_data.wdata;
        else hdr_limit = cfg_data.wdata[7:0];
      end
      // check outputs before taking this edge's input so a stray beat is never masked
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report($sformatf("result beat %h with nothing pending", out_data));
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          mism = "";
          if (out_data.body_valid !== want.body_valid) mism = {mism, " body_valid"};
          if (out_data.body_byte !== want.body_byte) mism = {mism, " body_byte"};
          if (out_data.chunk_last !== want.chunk_last) mism = {mism, " chunk_last"};
          if (out_data.message_done !== want.message_done) mism = {mism, " message_done"};
          if (out_data.status !== want.status) mism = {mism, " status"};
          if (mism != "")
            report($sformatf("result %0d wrong%s: got %h want %h",
                             results_checked, mism, out_data, want));
        end
      end
      if (in_valid && in_ready) pending_results.push_back(deframe_step(in_data));
    end
    outstanding <= pending_results.size();
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  import dfr_pkg::*;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_EOS  = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  dfr_chan_if #(.T(in_beat_t))  din_if ();
  dfr_chan_if #(.T(out_beat_t)) dout_if ();
  dfr_chan_if #(.T(cfg_beat_t)) cfg_if ();

  http_chunked_body_deframer DUT (
    .clk (clk),
    .rst (rst),
    .din (din_if),
    .dout(dout_if),
    .cfg (cfg_if)
  );

  int fail_count;
  int outstanding;
  int results_checked;
  int messages_done;

  chunk_deframe_monitor monitor_u (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (din_if.valid),
    .in_ready       (din_if.ready),
    .in_data        (din_if.data),
    .out_valid      (dout_if.valid),
    .out_ready      (dout_if.ready),
    .out_data       (dout_if.data),
    .cfg_valid      (cfg_if.valid),
    .cfg_ready      (cfg_if.ready),
    .cfg_data       (cfg_if.data),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .results_checked(results_checked),
    .messages_done  (messages_done)
  );

  bit          idling_on = 1'b1;
  int          sink_hold = 0;
  int          beats_sent = 0;
  int          settings_used = 1;
  logic [31:0] cur_limit = DEFAULT_PACKAGE_LIMIT;
  bit          fresh;
  in_beat_t    stream_q[$];

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      dout_if.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      sink_hold <= $urandom_range(0, 17);
      dout_if.ready <= 1'b0;
    end else begin
      dout_if.ready <= 1'b1;
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] pick_prior_len();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        if (cur_limit > 40) return cur_limit - $urandom_range(0, 40);
        return $urandom_range(0, cur_limit);
      end
      default: return $urandom_range(0, 120);
    endcase
  endfunction

  function automatic void add(logic kind, logic [7:0] c);
    in_beat_t b;
    b.kind = kind;
    b.data_byte = c;
    b.start_req = 1'b0;
    // head fields only matter with a start; keep them toggling anyway
    b.prior_length = $urandom;
    b.prior_headers = rand_byte();
    if (fresh) begin
      b.start_req = 1'b1;
      b.prior_length = pick_prior_len();
      if ($urandom_range(0, 7) == 0) b.prior_headers = rand_byte();
      else b.prior_headers = 8'($urandom_range(0, 3));
      fresh = 1'b0;
    end
    stream_q.push_back(b);
  endfunction

  function automatic logic [7:0] no_lf_char();
    logic [7:0] c;
    c = rand_byte();
    return (c == CH_LF) ? 8'h41 : c;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
    if (n < 10) return 8'h30 + n;
    return (upper ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic void add_eol();
    if ($urandom_range(0, 1)) add(KIND_BYTE, CH_CR);
    add(KIND_BYTE, CH_LF);
  endfunction

  function automatic void add_size_line(logic [35:0] v);
    int  top_n;
    bit  upper;
    upper = 1'($urandom_range(0, 1));
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
      add(KIND_BYTE, $urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0) add(KIND_BYTE, "0");
    top_n = 0;
    for (int i = 0; i < 9; i++) if (v[i*4 +: 4] != 0) top_n = i;
    for (int i = top_n; i >= 0; i--) add(KIND_BYTE, hex_char(v[i*4 +: 4], upper));
    if ($urandom_range(0, 3) == 0) begin
      add(KIND_BYTE, CH_SEMI);
      repeat ($urandom_range(0, 3)) add(KIND_BYTE, no_lf_char());
    end
    add_eol();
  endfunction

  function automatic void corrupt_stream();
    int       pos;
    in_beat_t b;
    pos = $urandom_range(1, stream_q.size() - 1);
    case ($urandom_range(0, 2))
      0: stream_q[pos].data_byte = rand_byte();
      1: begin
        // cut the message short and close the stream
        while (stream_q.size() > pos) void'(stream_q.pop_back());
        add(KIND_EOS, rand_byte());
      end
      default: begin
        b = stream_q[pos];
        b.start_req = 1'b0;
        b.kind = KIND_BYTE;
        case ($urandom_range(0, 6))
          0: b.data_byte = "+";
          1: b.data_byte = "-";
          2: b.data_byte = "x";
          3: b.data_byte = CH_SPACE;
          4: b.data_byte = 8'h00;
          5: b.data_byte = CH_CR;
          default: b.data_byte = rand_byte();
        endcase
        stream_q.insert(pos, b);
      end
    endcase
  endfunction

  function automatic void build_message();
    int          sz;
    logic [31:0] wild;
    fresh = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(3, 12)) begin
        if ($urandom_range(0, 5) == 0) fresh = 1'b1;
        add(($urandom_range(0, 15) == 0) ? KIND_EOS : KIND_BYTE, rand_byte());
      end
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      sz = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      add_size_line(36'(sz));
      repeat (sz) add(KIND_BYTE, rand_byte());
      add_eol();
    end
    if ($urandom_range(0, 19) == 0) begin
      // oversized chunk: stop after its size line
      wild = $urandom;
      case ($urandom_range(0, 3))
        0: add_size_line(36'h0_7FFF_FFFF);
        1: add_size_line(36'h0_8000_0000);
        2: add_size_line(36'h1_0000_0000);
        default: add_size_line({4'h0, wild});
      endcase
      if ($urandom_range(0, 1)) add(KIND_EOS, rand_byte());
      return;
    end
    add_size_line(36'd0);
    repeat ($urandom_range(0, 2)) begin
      repeat ($urandom_range(1, 5)) add(KIND_BYTE, no_lf_char());
      add_eol();
    end
    add_eol();
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) add(KIND_BYTE, rand_byte());
    if ($urandom_range(0, 2) == 0) add(KIND_EOS, rand_byte());
    if ($urandom_range(0, 4) == 0) corrupt_stream();
  endfunction

  task automatic send_beat(in_beat_t b);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      din_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    din_if.valid <= 1'b1;
    din_if.data <= b;
    @(posedge clk);
    while (!din_if.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_stream();
    while (stream_q.size() > 0) send_beat(stream_q.pop_front());
  endtask

  // hold the sender until every result is back
  task automatic drain();
    din_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic [31:0] limit, logic [7:0] hdr);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= cfg_beat_t'{addr: CFG_PACKAGE_LIMIT, wdata: limit};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.data <= cfg_beat_t'{addr: CFG_HEADER_LIMIT, wdata: {24'd0, hdr}};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    cur_limit = (limit == '0) ? DEFAULT_PACKAGE_LIMIT : limit;
    settings_used++;
  endtask

  task automatic run_phase(int target);
    int base;
    base = beats_sent;
    while (beats_sent - base < target) begin
      build_message();
      send_stream();
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  initial begin
    din_if.valid = 1'b0;
    din_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // blanks, extension, CR LF and bare LF, a trailer line, bytes after done, clean close
    fresh = 1'b1;
    add(KIND_BYTE, CH_SPACE);
    stream_q[0].prior_length = '0;
    stream_q[0].prior_headers = '0;
    add(KIND_BYTE, CH_TAB);
    add(KIND_BYTE, "0");
    add(KIND_BYTE, "2");
    add(KIND_BYTE, CH_SEMI);
    add(KIND_BYTE, "Q");
    add(KIND_BYTE, CH_CR);
    add(KIND_BYTE, CH_LF);
    add(KIND_BYTE, 8'h00);
    add(KIND_BYTE, 8'hFF);
    add(KIND_BYTE, CH_LF);
    add(KIND_BYTE, "0");
    add(KIND_BYTE, CH_CR);
    add(KIND_BYTE, CH_LF);
    add(KIND_BYTE, "X");
    add(KIND_BYTE, CH_CR);
    add(KIND_BYTE, CH_LF);
    add(KIND_BYTE, CH_CR);
    add(KIND_BYTE, CH_LF);
    add(KIND_BYTE, "Z");
    add(KIND_EOS, 8'h00);
    // hex prefix is rejected
    fresh = 1'b1;
    add(KIND_BYTE, "0");
    add(KIND_BYTE, "x");
    // start and close at once, with the head fields at their maximum
    fresh = 1'b1;
    add(KIND_EOS, 8'hFF);
    stream_q[$].prior_length = '1;
    stream_q[$].prior_headers = '1;
    send_stream();

    drain();
    configure(32'd0, 8'd255);
    run_phase(200);
    drain();
    configure(32'hFFFF_FFFF, 8'd0);
    run_phase(200);
    drain();
    configure(32'd1, 8'd128);
    run_phase(40);
    drain();
    configure($urandom_range(30, 300), 8'($urandom_range(1, 4)));
    run_phase(200);
    drain();
    configure($urandom, rand_byte());
    run_phase(200);
    drain();
    idling_on = 1'b0;
    configure(32'hFFFF_FFFF, 8'd255);
    run_phase(200);
    drain();

    $display("Covered %0d input beats under %0d limit settings:",
             beats_sent, settings_used);
    $display("  %0d results checked, %0d messages completed.",
             results_checked, messages_done);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
